>>> design/i2cmbe_pkg.sv
package i2cmbe_pkg;

   // Bus command codes
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_GACK  = 3'd4,
      OP_SACK  = 3'd5,
      OP_SNACK = 3'd6,
      OP_READ  = 3'd7
   } op_type;

   localparam int PHASE_W = 6;

   // Phase index of a command's final quantum
   localparam logic [PHASE_W-1:0] LAST_START = PHASE_W'(5);
   localparam logic [PHASE_W-1:0] LAST_STOP  = PHASE_W'(5);
   localparam logic [PHASE_W-1:0] LAST_WRITE = PHASE_W'(23);
   localparam logic [PHASE_W-1:0] LAST_ACK   = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] LAST_READ  = PHASE_W'(31);

   // Classified quantum passed from front to back
   typedef struct packed {
      op_type               op;
      logic                 has_cmd;
      logic [PHASE_W-1:0]   last_ph;
      logic [7:0]           tx;
      logic                 sda;
   } item_type;

   function automatic logic [PHASE_W-1:0] cmd_last(input op_type op);
      logic [PHASE_W-1:0] res;
      res = '0;
      unique case (op)
         OP_START:                  res = LAST_START;
         OP_STOP:                   res = LAST_STOP;
         OP_WRITE:                  res = LAST_WRITE;
         OP_GACK, OP_SACK, OP_SNACK: res = LAST_ACK;
         OP_READ:                   res = LAST_READ;
         default:                   res = '0;
      endcase
      return res;
   endfunction

endpackage

>>> design/i2cmbe_front.sv
module i2cmbe_front
   import i2cmbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_operation,
   input  logic [7:0]    req_tx_byte,
   input  logic          req_sda_level,
   output logic          item_valid,
   input  logic          item_ready,
   output item_type      item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   // Stage is free when empty or draining this cycle
   assign req_ready = !valid_ff || item_ready;
   assign load      = req_valid && req_ready;

   // Classify the incoming quantum
   always_comb begin
      item_in.op      = op_type'(req_operation);
      item_in.has_cmd = (op_type'(req_operation) != OP_NONE);
      item_in.last_ph = cmd_last(op_type'(req_operation));
      item_in.tx      = req_tx_byte;
      item_in.sda     = req_sda_level;
   end

   assign valid_in = load ? 1'b1 : (item_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/i2cmbe_queue.sv
module i2cmbe_queue
   import i2cmbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  item_type      push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output item_type      pop_item
);

   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue occupancy out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |=> (count_ff != 2'd3))
      else $error("queue pop underflow");
`endif

endmodule

>>> design/i2cmbe_back.sv
module i2cmbe_back
   import i2cmbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  item_type      item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_scl_level,
   output logic          rsp_sda_release,
   output logic          rsp_busy_res,
   output logic [7:0]    rsp_rx_byte,
   output logic          rsp_rx_done,
   output logic          rsp_ack_bit
);

   // Sequencer state
   op_type               active_ff, active_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [PHASE_W-1:0]   last_ff, last_in;
   logic [1:0]           sub_ff, sub_in;
   logic [7:0]           shift_ff, shift_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 ack_ff, ack_in;
   logic [7:0]           rx_ff, rx_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   logic [7:0]           rsp_rx_ff;

   // Effective values for this quantum
   logic                 start;
   op_type               act;
   logic [PHASE_W-1:0]   ph;
   logic [PHASE_W-1:0]   lastp;
   logic [7:0]           sh;
   logic [1:0]           sub;
   logic                 busy;
   logic                 is_last;
   logic                 scl, sda;
   logic                 done;
   logic                 fire;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   // A command is taken only while idle
   always_comb begin
      start   = item_valid && (active_ff == OP_NONE) && item.has_cmd;
      act     = start ? item.op : active_ff;
      ph      = start ? '0 : phase_ff;
      lastp   = start ? item.last_ph : last_ff;
      sh      = start ? ((item.op == OP_WRITE) ? item.tx : 8'd0) : shift_ff;
      sub     = start ? 2'd0 : sub_ff;
      busy    = (act != OP_NONE);
      is_last = busy && (ph == lastp);
   end

   // Line levels for this quantum
   always_comb begin
      scl = scl_ff;
      sda = sda_ff;
      unique case (act)
         OP_NONE: begin
            scl = scl_ff;
            sda = sda_ff;
         end
         OP_START: begin
            scl = (ph < PHASE_W'(4));
            sda = (ph < PHASE_W'(2));
         end
         OP_STOP: begin
            scl = (ph >= PHASE_W'(2));
            sda = (ph >= PHASE_W'(4));
         end
         OP_WRITE: begin
            scl = (sub == 2'd1);
            sda = sh[7];
         end
         OP_GACK: begin
            scl = (ph == PHASE_W'(1));
            sda = 1'b1;
         end
         OP_SACK: begin
            scl = (ph == PHASE_W'(1));
            sda = 1'b0;
         end
         OP_SNACK: begin
            scl = (ph == PHASE_W'(1));
            sda = 1'b1;
         end
         OP_READ: begin
            scl = ph[1];
            sda = 1'b1;
         end
         default: begin
            scl = scl_ff;
            sda = sda_ff;
         end
      endcase
   end

   // Next sequencer state
   always_comb begin
      shift_in = sh;
      if (act == OP_WRITE && sub == 2'd2) begin
         shift_in = {sh[6:0], 1'b0};
      end else if (act == OP_READ && ph[1:0] == 2'd2) begin
         shift_in = {sh[6:0], item.sda};
      end
      done   = (act == OP_READ) && is_last;
      rx_in  = done ? shift_in : rx_ff;
      ack_in = (act == OP_GACK && ph == PHASE_W'(1)) ? item.sda : ack_ff;
      sda_in = busy ? sda : sda_ff;
      scl_in = busy ? scl : scl_ff;
      if (is_last && (act == OP_GACK || act == OP_SACK || act == OP_SNACK)) begin
         scl_in = 1'b0;
      end
      active_in = is_last ? OP_NONE : act;
      phase_in  = (is_last || !busy) ? '0 : ph + PHASE_W'(1);
      sub_in    = (is_last || !busy) ? 2'd0 : ((sub == 2'd2) ? 2'd0 : sub + 2'd1);
      last_in   = lastp;
   end

   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= OP_NONE;
         phase_ff     <= '0;
         sub_ff       <= 2'd0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b1;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            active_ff <= active_in;
            phase_ff  <= phase_in;
            sub_ff    <= sub_in;
            shift_ff  <= shift_in;
            scl_ff    <= scl_in;
            sda_ff    <= sda_in;
            ack_ff    <= ack_in;
            rx_ff     <= rx_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (fire) begin
         last_ff     <= last_in;
         rsp_scl_ff  <= scl;
         rsp_sda_ff  <= sda;
         rsp_busy_ff <= busy;
         rsp_rx_ff   <= rx_in;
         rsp_done_ff <= done;
         rsp_ack_ff  <= ack_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_scl_ff;
   assign rsp_sda_release = rsp_sda_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_rx_byte     = rsp_rx_ff;
   assign rsp_rx_done     = rsp_done_ff;
   assign rsp_ack_bit     = rsp_ack_ff;

`ifndef SYNTH
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (active_ff == OP_NONE) |-> (phase_ff == '0 && sub_ff == 2'd0))
      else $error("idle sequencer holds a nonzero phase");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      (active_ff != OP_NONE) |-> (phase_ff <= last_ff && sub_ff != 2'd3))
      else $error("phase ran past the end of the command");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_busy_ff && rsp_scl_ff && rsp_sda_ff))
      else $error("read completion outside a read quantum");
`endif

endmodule

>>> design/i2c_master_bit_engine_unit.sv
// I2C master bit engine. Each transfer on the req_ channel is one 5 us bus quantum
// carrying an optional command, the byte to send and the sampled SDA level; each
// quantum yields exactly one rsp_ transfer with the SCL/SDA levels, busy, the last
// read byte with its done strobe, and the last sampled acknowledge bit. Commands
// arriving while a command is in progress are ignored. The engine sustains one
// quantum per clock while neither side stalls; the sequencer advances one phase
// per quantum. The result passes the input classify register, the two-entry queue
// and the output register before rsp_valid rises; either side may stall without
// losing data.
module i2c_master_bit_engine_unit
   import i2cmbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_operation,
   input  logic [7:0]    req_tx_byte,
   input  logic          req_sda_level,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_scl_level,
   output logic          rsp_sda_release,
   output logic          rsp_busy_res,
   output logic [7:0]    rsp_rx_byte,
   output logic          rsp_rx_done,
   output logic          rsp_ack_bit
);

   logic     front_valid, front_ready;
   item_type front_item;
   logic     back_valid, back_ready;
   item_type back_item;

   i2cmbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_tx_byte   (req_tx_byte),
      .req_sda_level (req_sda_level),
      .item_valid    (front_valid),
      .item_ready    (front_ready),
      .item          (front_item)
   );

   i2cmbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   i2cmbe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (back_valid),
      .item_ready      (back_ready),
      .item            (back_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_done     (rsp_rx_done),
      .rsp_ack_bit     (rsp_ack_bit)
   );

endmodule

>>> sim/i2c_master_bit_engine_unit_tb.sv
module i2c_master_bit_engine_unit_tb;
   import i2cmbe_pkg::*;

   localparam int RANDOM_ITEMS = 1740;
   localparam int PLAN_ROWS    = 17;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;

   // Line levels and status of one quantum
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic [7:0] rxb;
      logic       done;
      logic       ack;
   } bus_levels_type;

   // One directed row: the same quantum repeated reps times
   typedef struct packed {
      op_type         op;
      logic [7:0]     tx;
      logic           sda;
      logic [5:0]     reps;
      logic           typed;
      bus_levels_type want;
   } quantum_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_operation = OP_NONE;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_sda_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_release;
   logic       rsp_busy_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_rx_done;
   logic       rsp_ack_bit;

   // Engine state as the predictor sees it
   op_type     eng_cmd;
   logic [5:0] eng_phase;
   logic [7:0] eng_shift;
   logic       eng_scl;
   logic       eng_sda;
   logic       eng_ack;
   logic [7:0] eng_rx;

   bus_levels_type  expected_levels[$];
   quantum_row_type plan [PLAN_ROWS];
   int              error_count = 0;
   int              rsp_count = 0;
   int              burst_left = 0;
   int              idle_cycles = 0;
   int              stall_mode = 0;
   int              stall_left = 0;
   logic [7:0]      rx_cycle = 8'h00;

   i2c_master_bit_engine_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_tx_byte     (req_tx_byte),
      .req_sda_level   (req_sda_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_done     (rsp_rx_done),
      .rsp_ack_bit     (rsp_ack_bit)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the engine by one quantum and return the levels it shows
   function automatic bus_levels_type advance_engine(input op_type op, input logic [7:0] tx,
                                                     input logic sda_in);
      bus_levels_type r;
      logic [5:0]     p;
      logic           last;
      int             bit_idx;
      r.scl  = eng_scl;
      r.sda  = eng_sda;
      r.busy = 1'b0;
      r.done = 1'b0;
      last   = 1'b0;
      // a command is taken only while idle, and starts in this quantum
      if (eng_cmd == OP_NONE && op != OP_NONE) begin
         eng_cmd   = op;
         eng_phase = '0;
         eng_shift = (op == OP_WRITE) ? tx : 8'h00;
      end
      if (eng_cmd != OP_NONE) begin
         p = eng_phase;
         r.busy = 1'b1;
         case (eng_cmd)
            OP_START: begin
               last  = (p == LAST_START);
               r.scl = (p < 6'd4);
               r.sda = (p < 6'd2);
            end
            OP_STOP: begin
               last  = (p == LAST_STOP);
               r.scl = (p >= 6'd2);
               r.sda = (p >= 6'd4);
            end
            OP_WRITE: begin
               last    = (p == LAST_WRITE);
               bit_idx = 7 - int'(p) / 3;
               r.sda   = eng_shift[bit_idx];
               r.scl   = ((p % 3) == 1);
            end
            OP_GACK: begin
               last  = (p == LAST_ACK);
               r.sda = 1'b1;
               r.scl = (p == 6'd1);
               if (p == 6'd1) eng_ack = sda_in;
            end
            OP_SACK, OP_SNACK: begin
               last  = (p == LAST_ACK);
               r.sda = (eng_cmd == OP_SNACK);
               r.scl = (p == 6'd1);
            end
            default: begin
               // read: sample in the first clock-high quantum of each bit
               last  = (p == LAST_READ);
               r.sda = 1'b1;
               r.scl = p[1];
               if (p[1:0] == 2'd2) eng_shift = {eng_shift[6:0], sda_in};
               if (last) begin
                  eng_rx = eng_shift;
                  r.done = 1'b1;
               end
            end
         endcase
         eng_scl = r.scl;
         eng_sda = r.sda;
         if (last) begin
            // acknowledge phases leave SCL low
            if (eng_cmd == OP_GACK || eng_cmd == OP_SACK || eng_cmd == OP_SNACK)
               eng_scl = 1'b0;
            eng_cmd   = OP_NONE;
            eng_phase = '0;
         end else begin
            eng_phase = p + 6'd1;
         end
      end
      r.rxb = eng_rx;
      r.ack = eng_ack;
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("mismatch on %s at rsp transfer %0d: got %0d, want %0d",
               field, rsp_count, got, want);
      error_count++;
   endtask

   // Sender bursts: random gaps between bursts of random length
   task automatic pace_sender();
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
   endtask

   // Offer one quantum, wait for its transfer, record what it should yield
   task automatic send_quantum(input op_type op, input logic [7:0] tx, input logic sda,
                               input logic typed, input bus_levels_type want);
      bus_levels_type model;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_tx_byte   <= tx;
      req_sda_level <= sda;
      do @(posedge clock); while (!req_ready);
      model = advance_engine(op, tx, sda);
      expected_levels.push_back(typed ? want : model);
      burst_left--;
   endtask

   // Receiver stall pattern and result check
   always @(posedge clock) begin : rsp_side
      bus_levels_type want;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= rx_cycle[0];
         2:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (rx_cycle[3:0] >= 4'd12);
      endcase
      rx_cycle <= rx_cycle + 8'd1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            flag_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_scl_level !== want.scl) flag_mismatch("scl_level", rsp_scl_level, want.scl);
            if (rsp_sda_release !== want.sda)
               flag_mismatch("sda_release", rsp_sda_release, want.sda);
            if (rsp_busy_res !== want.busy) flag_mismatch("busy_res", rsp_busy_res, want.busy);
            if (rsp_rx_byte !== want.rxb) flag_mismatch("rx_byte", rsp_rx_byte, want.rxb);
            if (rsp_rx_done !== want.done) flag_mismatch("rx_done", rsp_rx_done, want.done);
            if (rsp_ack_bit !== want.ack) flag_mismatch("ack_bit", rsp_ack_bit, want.ack);
         end
         rsp_count++;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      op_type     op;
      logic [7:0] tx;
      logic       sda;
      eng_cmd   = OP_NONE;
      eng_phase = '0;
      eng_shift = 8'h00;
      eng_scl   = 1'b1;
      eng_sda   = 1'b1;
      eng_ack   = 1'b1;
      eng_rx    = 8'h00;

      // op, tx, sda, reps, typed, want {scl, sda, busy, rx, done, ack}
      plan = '{
         // idle right after reset: lines released
         '{OP_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
         // start begins in the quantum it arrives
         '{OP_START, 8'hFF, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1}},
         // commands while busy are dropped, last quantum too
         '{OP_STOP,  8'h00, 1'b0, 6'd5,  1'b0, '0},
         // idle holds the levels left by start
         '{OP_NONE,  8'h00, 1'b1, 6'd2,  1'b0, '0},
         '{OP_WRITE, 8'hFF, 1'b0, 6'd24, 1'b0, '0},
         '{OP_WRITE, 8'h00, 1'b1, 6'd24, 1'b0, '0},
         // write end: SCL low, SDA keeps the last data bit
         '{OP_NONE,  8'hFF, 1'b0, 6'd1,  1'b0, '0},
         '{OP_GACK,  8'h00, 1'b0, 6'd2,  1'b0, '0},
         '{OP_GACK,  8'h00, 1'b1, 6'd2,  1'b0, '0},
         '{OP_SACK,  8'h00, 1'b0, 6'd2,  1'b0, '0},
         '{OP_SNACK, 8'h00, 1'b0, 6'd2,  1'b0, '0},
         '{OP_READ,  8'h00, 1'b1, 6'd32, 1'b0, '0},
         // read end: SCL stays high, SDA released
         '{OP_NONE,  8'h00, 1'b0, 6'd2,  1'b0, '0},
         '{OP_READ,  8'hFF, 1'b0, 6'd32, 1'b0, '0},
         '{OP_WRITE, 8'hA5, 1'b1, 6'd24, 1'b0, '0},
         '{OP_STOP,  8'hFF, 1'b1, 6'd6,  1'b0, '0},
         // bus released after stop; last read 00, last ack 1
         '{OP_NONE,  8'h00, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed quanta
      foreach (plan[i]) begin
         for (int n = 0; n < int'(plan[i].reps); n++) begin
            pace_sender();
            send_quantum(plan[i].op, plan[i].tx, plan[i].sda, plan[i].typed, plan[i].want);
         end
      end

      // random quanta: mostly new commands when idle, noise while busy
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 0 || i == RANDOM_ITEMS / 2) begin
            // hold off until every outstanding result has transferred
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_levels.size() != 0);
         end else begin
            pace_sender();
         end
         if (eng_cmd == OP_NONE)
            op = ($urandom_range(0, 99) < 85) ? op_type'($urandom_range(1, 7)) : OP_NONE;
         else
            op = ($urandom_range(0, 99) < 15) ? op_type'($urandom_range(1, 7)) : OP_NONE;
         case ($urandom_range(0, 9))
            0:       tx = 8'h00;
            1:       tx = 8'hFF;
            default: tx = 8'($urandom_range(0, 255));
         endcase
         sda = 1'($urandom_range(0, 1));
         send_quantum(op, tx, sda, 1'b0, '0);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_levels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
